[rtl/lcdms_pkg.sv]
// ----------------------------------------------------------------------------
// LCD mode/line/STAT sequencer package
// Shared types and default timing constants: mode codes, interrupt enable
// bit positions and the input and result item structs.
// ----------------------------------------------------------------------------
package lcdms_pkg;

	// Default timing: mode lengths, line length and frame line counts
	localparam int unsigned DEF_SEARCH_CYCLES   = 80;
	localparam int unsigned DEF_TRANSFER_CYCLES = 172;
	localparam int unsigned DEF_HBLANK_CYCLES   = 204;
	localparam int unsigned DEF_LINE_CYCLES     = 456;
	localparam int unsigned DEF_VISIBLE_LINES   = 144;
	localparam int unsigned DEF_TOTAL_LINES     = 154;

	// Field widths
	localparam int unsigned CYCLE_WIDTH = 8;
	localparam int unsigned LY_WIDTH    = 8;
	localparam int unsigned IEN_WIDTH   = 4;

	// Interrupt enable bit positions in int_enables
	localparam int unsigned IEN_HBLANK      = 0;
	localparam int unsigned IEN_VBLANK      = 1;
	localparam int unsigned IEN_SEARCH      = 2;
	localparam int unsigned IEN_COINCIDENCE = 3;

	typedef enum logic [1:0] {
		MODE_HBLANK   = 2'd0,
		MODE_VBLANK   = 2'd1,
		MODE_SEARCH   = 2'd2,
		MODE_TRANSFER = 2'd3
	} mode_t;

	typedef struct packed {
		logic [CYCLE_WIDTH-1:0] elapsed_cycles;
		logic                   display_on;
		logic [LY_WIDTH-1:0]    compare_line;
		logic [IEN_WIDTH-1:0]   int_enables;
	} in_item_t;

	typedef struct packed {
		logic                updated;
		logic [1:0]          mode;
		logic [LY_WIDTH-1:0] line;
		logic                coincidence;
		logic                vblank_irq;
		logic                stat_irq;
		logic                line_render;
		logic                frame_done;
	} out_item_t;

endpackage

[rtl/lcdms_core.sv]
// ----------------------------------------------------------------------------
// LCD sequencer core
// Holds the countdown, mode and line state and works out one tick's
// transition and status refresh in a single pass of combinational logic.
// ----------------------------------------------------------------------------
module lcdms_core #(
	parameter int unsigned SEARCH_CYCLES   = lcdms_pkg::DEF_SEARCH_CYCLES,
	parameter int unsigned TRANSFER_CYCLES = lcdms_pkg::DEF_TRANSFER_CYCLES,
	parameter int unsigned HBLANK_CYCLES   = lcdms_pkg::DEF_HBLANK_CYCLES,
	parameter int unsigned LINE_CYCLES     = lcdms_pkg::DEF_LINE_CYCLES,
	parameter int unsigned VISIBLE_LINES   = lcdms_pkg::DEF_VISIBLE_LINES,
	parameter int unsigned TOTAL_LINES     = lcdms_pkg::DEF_TOTAL_LINES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  lcdms_pkg::in_item_t   item,
	output lcdms_pkg::out_item_t  result
);

	localparam int unsigned LW      = lcdms_pkg::LY_WIDTH;
	localparam int unsigned LINES   = 2**LW;

	typedef logic [LINES-1:0][LW-1:0] line_table_t;

	// Next vblank line for every current line: (line + 1) wrapped at the frame length
	function automatic line_table_t vblank_next_table(input int unsigned total);
		line_table_t tbl;
		int unsigned m;
		m = 0;
		for (int i = 0; i < LINES; i++) begin
			if (m + 1 == total) begin
				m = 0;
			end else begin
				m = m + 1;
			end
			tbl[i] = LW'(m);
		end
		return tbl;
	endfunction

	localparam logic signed [11:0] CD_MIN   = -12'sd1024;
	localparam logic signed [11:0] CD_MAX   = 12'sd1023;
	localparam logic [9:0]         LEN_SRCH = 10'(SEARCH_CYCLES);
	localparam logic [9:0]         LEN_XFER = 10'(TRANSFER_CYCLES);
	localparam logic [9:0]         LEN_HBLK = 10'(HBLANK_CYCLES);
	localparam logic [9:0]         LEN_LINE = 10'(LINE_CYCLES);
	localparam logic [LW-1:0]      VIS_LINE = LW'(VISIBLE_LINES);
	localparam logic [LW:0]        TOT_NXT  = (LW+1)'(TOTAL_LINES);
	localparam line_table_t        VBL_NEXT = vblank_next_table(TOTAL_LINES);

	function automatic logic signed [10:0] clamp_cd(input logic signed [11:0] v);
		if (v < CD_MIN) begin
			return CD_MIN[10:0];
		end else if (v > CD_MAX) begin
			return CD_MAX[10:0];
		end
		return v[10:0];
	endfunction

	// State
	logic signed [10:0]     cd_q, cd_d;
	lcdms_pkg::mode_t       cur_mode_q, cur_mode_d;
	lcdms_pkg::mode_t       pend_mode_q, pend_mode_d;
	logic [LW-1:0]          cur_line_q, cur_line_d;
	logic [LW-1:0]          pend_line_q, pend_line_d;
	logic                   stat_level_q, stat_level_d;
	logic                   coin_q, coin_d;

	// Working signals
	logic signed [11:0]     cd_dec;
	logic signed [10:0]     cd_dec_sat;
	logic [9:0]             mode_len;
	logic                   fire;
	logic [LW-1:0]          ly;
	logic [LW:0]            ly_inc;
	logic                   cond;
	logic                   vbl, sirq, render, frame;

	// Subtract the elapsed cycles and saturate
	assign cd_dec     = {cd_q[10], cd_q} - {4'd0, item.elapsed_cycles};
	assign cd_dec_sat = clamp_cd(cd_dec);
	assign fire       = item.display_on && (cd_dec_sat <= 11'sd0);
	assign ly         = pend_line_q;
	assign ly_inc     = {1'b0, pend_line_q} + (LW+1)'(1);

	// Length of the mode being entered
	always_comb begin
		unique case (pend_mode_q)
			lcdms_pkg::MODE_SEARCH:   mode_len = LEN_SRCH;
			lcdms_pkg::MODE_TRANSFER: mode_len = LEN_XFER;
			lcdms_pkg::MODE_HBLANK:   mode_len = LEN_HBLK;
			lcdms_pkg::MODE_VBLANK:   mode_len = LEN_LINE;
			default:                  mode_len = LEN_LINE;
		endcase
	end

	// Next state and pulses for this tick
	always_comb begin
		cd_d         = cd_q;
		cur_mode_d   = cur_mode_q;
		pend_mode_d  = pend_mode_q;
		cur_line_d   = cur_line_q;
		pend_line_d  = pend_line_q;
		stat_level_d = stat_level_q;
		coin_d       = coin_q;
		cond         = 1'b0;
		vbl          = 1'b0;
		sirq         = 1'b0;
		render       = 1'b0;
		frame        = 1'b0;
		if (!item.display_on) begin
			// Display off: park the sequencer at the top of the frame
			pend_mode_d = lcdms_pkg::MODE_SEARCH;
			cur_line_d  = '0;
			pend_line_d = '0;
			cd_d        = '0;
		end else begin
			cd_d = cd_dec_sat;
			if (fire) begin
				cur_mode_d = pend_mode_q;
				cur_line_d = ly;
				cd_d       = clamp_cd(12'(cd_dec_sat) + {2'b00, mode_len});
				unique case (pend_mode_q)
					lcdms_pkg::MODE_SEARCH: begin
						pend_mode_d = lcdms_pkg::MODE_TRANSFER;
					end
					lcdms_pkg::MODE_TRANSFER: begin
						render      = 1'b1;
						pend_mode_d = lcdms_pkg::MODE_HBLANK;
					end
					lcdms_pkg::MODE_HBLANK: begin
						pend_mode_d = (ly_inc < {1'b0, VIS_LINE}) ?
							lcdms_pkg::MODE_SEARCH : lcdms_pkg::MODE_VBLANK;
						pend_line_d = ly_inc[LW-1:0];
					end
					default: begin
						pend_mode_d = lcdms_pkg::MODE_VBLANK;
						pend_line_d = VBL_NEXT[ly];
						if (ly_inc == TOT_NXT) begin
							frame       = 1'b1;
							pend_mode_d = lcdms_pkg::MODE_SEARCH;
						end
					end
				endcase
				vbl    = (ly == VIS_LINE);
				coin_d = (ly == item.compare_line);
				cond   = (item.int_enables[lcdms_pkg::IEN_HBLANK] &&
						cur_mode_d == lcdms_pkg::MODE_HBLANK) ||
					(item.int_enables[lcdms_pkg::IEN_VBLANK] &&
						cur_mode_d == lcdms_pkg::MODE_VBLANK) ||
					(item.int_enables[lcdms_pkg::IEN_SEARCH] &&
						cur_mode_d == lcdms_pkg::MODE_SEARCH) ||
					(item.int_enables[lcdms_pkg::IEN_COINCIDENCE] && coin_d);
				// Fire STAT only on the rising edge of the condition
				sirq         = !stat_level_q && cond;
				stat_level_d = cond;
			end
		end
	end

	// Hold state; advance one tick per transfer out of the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_q         <= '0;
			cur_mode_q   <= lcdms_pkg::MODE_SEARCH;
			pend_mode_q  <= lcdms_pkg::MODE_SEARCH;
			cur_line_q   <= '0;
			pend_line_q  <= '0;
			stat_level_q <= 1'b0;
			coin_q       <= 1'b0;
		end else if (advance) begin
			cd_q         <= cd_d;
			cur_mode_q   <= cur_mode_d;
			pend_mode_q  <= pend_mode_d;
			cur_line_q   <= cur_line_d;
			pend_line_q  <= pend_line_d;
			stat_level_q <= stat_level_d;
			coin_q       <= coin_d;
		end
	end

	// Result of this tick
	always_comb begin
		result.updated     = fire;
		result.mode        = cur_mode_d;
		result.line        = cur_line_d;
		result.coincidence = coin_d;
		result.vblank_irq  = vbl;
		result.stat_irq    = sirq;
		result.line_render = render;
		result.frame_done  = frame;
	end

endmodule

[rtl/lcd_mode_line_stat_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// LCD mode/line/STAT sequencer
// Turns elapsed-cycle ticks into LCD mode transitions, line numbers and
// interrupt pulses, one result item per tick.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid, item_stall, item) carries one tick: the
//   cycles elapsed, the display enable, the compare line and the STAT
//   interrupt enables. The result channel (result_valid, result_stall,
//   result) returns exactly one status item per tick, in order.
//   A tick is registered at its transfer, evaluated against the sequencer
//   state and written to the result register, so its result passes two
//   register stages: the input register and the result register.
//   One tick per clock is sustained; the limit is the single state update
//   per cycle in the core, which a tick reaches only when the result
//   register is free or being emptied.
//   When result_stall is high the result holds and the input stage fills;
//   item_stall rises once the input stage holds a tick it cannot pass on.
//   Reset empties both stages and puts the sequencer at line 0, search
//   mode, countdown zero, so the first enabled tick enters search at once.
// ----------------------------------------------------------------------------
module lcd_mode_line_stat_sequencer_unit #(
	parameter int unsigned SEARCH_CYCLES   = lcdms_pkg::DEF_SEARCH_CYCLES,
	parameter int unsigned TRANSFER_CYCLES = lcdms_pkg::DEF_TRANSFER_CYCLES,
	parameter int unsigned HBLANK_CYCLES   = lcdms_pkg::DEF_HBLANK_CYCLES,
	parameter int unsigned LINE_CYCLES     = lcdms_pkg::DEF_LINE_CYCLES,
	parameter int unsigned VISIBLE_LINES   = lcdms_pkg::DEF_VISIBLE_LINES,
	parameter int unsigned TOTAL_LINES     = lcdms_pkg::DEF_TOTAL_LINES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  lcdms_pkg::in_item_t   item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output lcdms_pkg::out_item_t  result
);

	lcdms_pkg::in_item_t  item_s1;
	logic                 valid_s1;
	lcdms_pkg::out_item_t result_q;
	logic                 result_valid_q;
	lcdms_pkg::out_item_t core_result;
	logic                 advance;
	logic                 accept;

	// Move the input stage on when the result register is free or draining
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	lcdms_core #(
		.SEARCH_CYCLES   (SEARCH_CYCLES),
		.TRANSFER_CYCLES (TRANSFER_CYCLES),
		.HBLANK_CYCLES   (HBLANK_CYCLES),
		.LINE_CYCLES     (LINE_CYCLES),
		.VISIBLE_LINES   (VISIBLE_LINES),
		.TOTAL_LINES     (TOTAL_LINES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.result  (core_result)
	);

	// Result register; drop valid after a transfer with nothing behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= core_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[rtl/lcdms_checker.sv]
// ----------------------------------------------------------------------------
// LCD sequencer port checker
// Watches the top-level ports for handshake and status pulse consistency.
// ----------------------------------------------------------------------------
module lcdms_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  item_valid,
	input logic                  item_stall,
	input lcdms_pkg::in_item_t   item,
	input logic                  result_valid,
	input logic                  result_stall,
	input lcdms_pkg::out_item_t  result
);

	// A stalled tick stays offered and unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("tick changed while stalled");

	// A stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result valid dropped while stalled");

	// Pulses only come with a transition
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.updated |->
			!result.vblank_irq && !result.stat_irq &&
			!result.line_render && !result.frame_done)
		else $error("status pulse without a transition");

	// Scanline drawing starts only on entry to transfer mode
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.line_render |->
			result.mode == lcdms_pkg::MODE_TRANSFER)
		else $error("line render outside transfer mode");

	// A frame ends only from a vblank line
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.frame_done |->
			result.mode == lcdms_pkg::MODE_VBLANK && !result.line_render)
		else $error("frame done outside vblank");

endmodule

bind lcd_mode_line_stat_sequencer_unit lcdms_checker u_checker (.*);
